// ===== rtl/core/obar_pkg.sv =====
`default_nettype none
package obar_pkg;

   localparam int TIME_W = 63;
   localparam int PRICE_W = 32;
   localparam int MIN_W = 11;
   localparam int PERIOD_W = 47;
   localparam int NUM_PRICES = 8;
   localparam int QUEUE_DEPTH = 2;
   localparam logic [PERIOD_W-1:0] NS_PER_MINUTE = 47'd60000000000;

   // price slots: bid open, close, high, low; ask open, close, high, low
   localparam int P_OPEN = 0;
   localparam int P_CLOSE = 1;
   localparam int P_HIGH = 2;
   localparam int P_LOW = 3;

   typedef struct packed {
      logic [TIME_W-1:0] start;
      logic [NUM_PRICES-1:0][PRICE_W-1:0] prices;
      logic [PRICE_W-1:0] volume;
   } bar_word_type;

endpackage
`default_nettype wire

// ===== rtl/core/obar_front.sv =====
`default_nettype none
module obar_front (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic req_ready,
   input  wire logic [obar_pkg::TIME_W-1:0] tick_time,
   input  wire logic [obar_pkg::NUM_PRICES-1:0][obar_pkg::PRICE_W-1:0] prices,
   input  wire logic [obar_pkg::PRICE_W-1:0] volume,
   input  wire logic [obar_pkg::MIN_W-1:0] bar_minutes,
   output logic push_valid,
   input  wire logic push_ready,
   output obar_pkg::bar_word_type push_data
);
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_CALC = 2'd1;
   localparam logic [1:0] S_DIV = 2'd2;
   localparam logic [1:0] S_PUSH = 2'd3;
   localparam int PW = obar_pkg::PERIOD_W;
   localparam int TW = obar_pkg::TIME_W;
   localparam int CW = $clog2(TW);

   logic [1:0] state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [TW-1:0] time_ff, time_in;
   logic [PW-1:0] period_ff, period_in;
   logic [PW-1:0] rem_ff, rem_in;
   logic [PW:0] rem_shift;
   logic [obar_pkg::NUM_PRICES-1:0][obar_pkg::PRICE_W-1:0] prices_ff, prices_in;
   logic [obar_pkg::PRICE_W-1:0] volume_ff, volume_in;
   logic [obar_pkg::MIN_W-1:0] minutes;

   assign minutes = (bar_minutes == '0) ? obar_pkg::MIN_W'(1) : bar_minutes;
   assign rem_shift = {rem_ff, time_ff[cnt_ff]};
   assign req_ready = (state_ff == S_IDLE);
   assign push_valid = (state_ff == S_PUSH);
   assign push_data.start = time_ff - TW'(rem_ff);
   assign push_data.prices = prices_ff;
   assign push_data.volume = volume_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      time_in = time_ff;
      period_in = period_ff;
      rem_in = rem_ff;
      prices_in = prices_ff;
      volume_in = volume_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               time_in = tick_time;
               prices_in = prices;
               volume_in = volume;
               state_in = S_CALC;
            end
         end
         S_CALC: begin
            period_in = PW'(minutes) * obar_pkg::NS_PER_MINUTE;
            rem_in = '0;
            cnt_in = CW'(TW - 1);
            state_in = S_DIV;
         end
         S_DIV: begin
            // restoring remainder, one time bit per cycle
            if (rem_shift >= {1'b0, period_ff}) begin
               rem_in = PW'(rem_shift - {1'b0, period_ff});
            end else begin
               rem_in = PW'(rem_shift);
            end
            if (cnt_ff == '0) begin
               state_in = S_PUSH;
            end else begin
               cnt_in = cnt_ff - CW'(1);
            end
         end
         S_PUSH: begin
            if (push_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cnt_ff <= cnt_in;
      time_ff <= time_in;
      period_ff <= period_in;
      rem_ff <= rem_in;
      prices_ff <= prices_in;
      volume_ff <= volume_in;
   end
endmodule
`default_nettype wire

// ===== rtl/core/obar_fifo.sv =====
`default_nettype none
module obar_fifo #(
   parameter int DEPTH = obar_pkg::QUEUE_DEPTH
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic push_valid,
   output logic push_ready,
   input  wire obar_pkg::bar_word_type push_data,
   output logic pop_valid,
   input  wire logic pop_ready,
   output obar_pkg::bar_word_type pop_data,
   output logic [$clog2(DEPTH+1)-1:0] count
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW = $clog2(DEPTH + 1);

   obar_pkg::bar_word_type mem [DEPTH];
   logic [AW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [NW-1:0] cnt_ff, cnt_in;
   logic do_push, do_pop;

   assign push_ready = (cnt_ff != NW'(DEPTH));
   assign pop_valid = (cnt_ff != '0);
   assign do_push = push_valid && push_ready;
   assign do_pop = pop_valid && pop_ready;
   assign pop_data = mem[rd_ff];
   assign count = cnt_ff;

   always_comb begin
      wr_in = wr_ff;
      rd_in = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == AW'(DEPTH - 1)) ? '0 : wr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == AW'(DEPTH - 1)) ? '0 : rd_ff + AW'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + NW'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) begin
         mem[wr_ff] <= push_data;
      end
   end
endmodule
`default_nettype wire

// ===== rtl/core/obar_back.sv =====
`default_nettype none
module obar_back (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic pop_valid,
   output logic pop_ready,
   input  wire obar_pkg::bar_word_type pop_data,
   output logic rsp_valid,
   input  wire logic rsp_ready,
   output logic new_bar,
   output logic bar_open,
   output obar_pkg::bar_word_type bar
);
   logic open_ff, open_in;
   logic valid_ff, valid_in;
   logic new_ff, new_in;
   obar_pkg::bar_word_type bar_ff, bar_in;
   logic fresh, take;

   assign pop_ready = !valid_ff || rsp_ready;
   assign take = pop_valid && pop_ready;
   assign fresh = !open_ff || (pop_data.start != bar_ff.start);
   assign rsp_valid = valid_ff;
   assign new_bar = new_ff;
   assign bar_open = open_ff;
   assign bar = bar_ff;

   always_comb begin
      open_in = open_ff;
      new_in = new_ff;
      bar_in = bar_ff;
      valid_in = valid_ff && !rsp_ready;
      if (take) begin
         valid_in = 1'b1;
         open_in = 1'b1;
         new_in = fresh;
         if (fresh) begin
            bar_in = pop_data;
         end else begin
            for (int s = 0; s < obar_pkg::NUM_PRICES; s += 4) begin
               if (pop_data.prices[s + obar_pkg::P_HIGH] >
                   bar_ff.prices[s + obar_pkg::P_HIGH]) begin
                  bar_in.prices[s + obar_pkg::P_HIGH] =
                     pop_data.prices[s + obar_pkg::P_HIGH];
               end
               if (pop_data.prices[s + obar_pkg::P_LOW] <
                   bar_ff.prices[s + obar_pkg::P_LOW]) begin
                  bar_in.prices[s + obar_pkg::P_LOW] =
                     pop_data.prices[s + obar_pkg::P_LOW];
               end
               bar_in.prices[s + obar_pkg::P_CLOSE] =
                  pop_data.prices[s + obar_pkg::P_CLOSE];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         open_ff <= open_in;
         valid_ff <= valid_in;
      end
      new_ff <= new_in;
      bar_ff <= bar_in;
   end
endmodule
`default_nettype wire

// ===== rtl/core/ohlc_bar_aggregator.sv =====
// OHLC bar aggregator: one price update in, one bar snapshot out. Each update
// passes through the front end (capture, period multiply, a bit-serial
// remainder unit that rounds the timestamp down to the bar length, then the
// hand-off into a two-word queue); the front end takes a new update once that
// word is queued. The back end compares against the open bar and updates it as
// it takes a word from the queue, holding the result in an output register.
// bar_minutes lives at byte address 0; a value of 0 means one minute.
`default_nettype none
module ohlc_bar_aggregator #(
   parameter int QUEUE_DEPTH = obar_pkg::QUEUE_DEPTH
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic psel,
   input  wire logic penable,
   input  wire logic pwrite,
   input  wire logic [2:0] paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic pready,
   input  wire logic req_valid,
   output logic req_ready,
   input  wire logic [62:0] req_tick_time,
   input  wire logic [31:0] req_bid_open,
   input  wire logic [31:0] req_bid_close,
   input  wire logic [31:0] req_bid_high,
   input  wire logic [31:0] req_bid_low,
   input  wire logic [31:0] req_ask_open,
   input  wire logic [31:0] req_ask_close,
   input  wire logic [31:0] req_ask_high,
   input  wire logic [31:0] req_ask_low,
   input  wire logic [31:0] req_trade_volume,
   output logic rsp_valid,
   input  wire logic rsp_ready,
   output logic rsp_new_bar,
   output logic [62:0] rsp_bar_start,
   output logic [31:0] rsp_out_bid_open,
   output logic [31:0] rsp_out_bid_close,
   output logic [31:0] rsp_out_bid_high,
   output logic [31:0] rsp_out_bid_low,
   output logic [31:0] rsp_out_ask_open,
   output logic [31:0] rsp_out_ask_close,
   output logic [31:0] rsp_out_ask_high,
   output logic [31:0] rsp_out_ask_low,
   output logic [31:0] rsp_out_volume
);
   logic [obar_pkg::MIN_W-1:0] minutes_ff;
   logic [obar_pkg::NUM_PRICES-1:0][obar_pkg::PRICE_W-1:0] in_prices;
   logic push_valid, push_ready, pop_valid, pop_ready, bar_open;
   logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;
   obar_pkg::bar_word_type push_data, pop_data, bar;

   assign pready = 1'b1;
   assign prdata = paddr[2] ? 32'd0 : 32'(minutes_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         minutes_ff <= obar_pkg::MIN_W'(1);
      end else if (psel && penable && pwrite && !paddr[2]) begin
         minutes_ff <= pwdata[obar_pkg::MIN_W-1:0];
      end
   end

   assign in_prices = {req_ask_low, req_ask_high, req_ask_close, req_ask_open,
                       req_bid_low, req_bid_high, req_bid_close, req_bid_open};

   obar_front u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .tick_time(req_tick_time), .prices(in_prices), .volume(req_trade_volume),
      .bar_minutes(minutes_ff),
      .push_valid(push_valid), .push_ready(push_ready), .push_data(push_data)
   );

   obar_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
      .clock(clock), .reset(reset),
      .push_valid(push_valid), .push_ready(push_ready), .push_data(push_data),
      .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_data(pop_data),
      .count(q_count)
   );

   obar_back u_back (
      .clock(clock), .reset(reset),
      .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_data(pop_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .new_bar(rsp_new_bar), .bar_open(bar_open), .bar(bar)
   );

   assign rsp_bar_start = bar.start;
   assign rsp_out_bid_open = bar.prices[0];
   assign rsp_out_bid_close = bar.prices[1];
   assign rsp_out_bid_high = bar.prices[2];
   assign rsp_out_bid_low = bar.prices[3];
   assign rsp_out_ask_open = bar.prices[4];
   assign rsp_out_ask_close = bar.prices[5];
   assign rsp_out_ask_high = bar.prices[6];
   assign rsp_out_ask_low = bar.prices[7];
   assign rsp_out_volume = bar.volume;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("front end took a second word while busy");

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_count <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_result_has_bar: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> bar_open)
      else $error("result shown with no open bar");

   a_pop_feeds_result: assert property (@(posedge clock) disable iff (reset)
      pop_valid && pop_ready |=> rsp_valid)
      else $error("queued word lost on its way to the output");
endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
module tb_top;
   localparam int TIME_W = obar_pkg::TIME_W;
   localparam int PRICE_W = obar_pkg::PRICE_W;
   localparam int MIN_W = obar_pkg::MIN_W;
   localparam int NUM_PRICES = obar_pkg::NUM_PRICES;
   localparam int P_OPEN = obar_pkg::P_OPEN;
   localparam int P_CLOSE = obar_pkg::P_CLOSE;
   localparam int P_HIGH = obar_pkg::P_HIGH;
   localparam int P_LOW = obar_pkg::P_LOW;

   localparam logic [2:0] REG_BAR_MINUTES = 3'd0;
   localparam bit [63:0] NS_MIN = 64'd60000000000;
   localparam int IDLE_LIMIT = 3000;
   localparam int HOLD_CYCLES = 600;

   typedef struct packed {
      bit [TIME_W-1:0] ts;
      bit [NUM_PRICES-1:0][PRICE_W-1:0] px;
      bit [PRICE_W-1:0] vol;
   } tick_type;

   typedef struct packed {
      bit fresh;
      bit [TIME_W-1:0] start;
      bit [NUM_PRICES-1:0][PRICE_W-1:0] px;
      bit [PRICE_W-1:0] vol;
   } bar_type;

   logic clock, reset;
   logic psel, penable, pwrite;
   logic [2:0] paddr;
   logic [31:0] pwdata, prdata;
   logic pready;
   logic req_valid, req_ready;
   logic [62:0] req_tick_time;
   logic [31:0] req_bid_open, req_bid_close, req_bid_high, req_bid_low;
   logic [31:0] req_ask_open, req_ask_close, req_ask_high, req_ask_low;
   logic [31:0] req_trade_volume;
   logic rsp_valid, rsp_ready, rsp_new_bar;
   logic [62:0] rsp_bar_start;
   logic [31:0] rsp_out_bid_open, rsp_out_bid_close, rsp_out_bid_high, rsp_out_bid_low;
   logic [31:0] rsp_out_ask_open, rsp_out_ask_close, rsp_out_ask_high, rsp_out_ask_low;
   logic [31:0] rsp_out_volume;

   ohlc_bar_aggregator u_dut (
      .clock(clock), .reset(reset),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_tick_time(req_tick_time),
      .req_bid_open(req_bid_open), .req_bid_close(req_bid_close),
      .req_bid_high(req_bid_high), .req_bid_low(req_bid_low),
      .req_ask_open(req_ask_open), .req_ask_close(req_ask_close),
      .req_ask_high(req_ask_high), .req_ask_low(req_ask_low),
      .req_trade_volume(req_trade_volume),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_new_bar(rsp_new_bar),
      .rsp_bar_start(rsp_bar_start),
      .rsp_out_bid_open(rsp_out_bid_open), .rsp_out_bid_close(rsp_out_bid_close),
      .rsp_out_bid_high(rsp_out_bid_high), .rsp_out_bid_low(rsp_out_bid_low),
      .rsp_out_ask_open(rsp_out_ask_open), .rsp_out_ask_close(rsp_out_ask_close),
      .rsp_out_ask_high(rsp_out_ask_high), .rsp_out_ask_low(rsp_out_ask_low),
      .rsp_out_volume(rsp_out_volume)
   );

   // model state
   bit [MIN_W-1:0] bar_minutes_q;
   bit bar_live;
   bit [TIME_W-1:0] bar_start_q;
   bit [NUM_PRICES-1:0][PRICE_W-1:0] bar_px;
   bit [PRICE_W-1:0] bar_vol;

   tick_type pending_ticks[$];
   bar_type expected_bars[$];
   tick_type drv_tick;
   int gap_left, stall_left, mismatches, words_in, words_out, new_bars, idle_cycles;
   int hold_cnt;
   bit hold_go, hold_done;
   bit [TIME_W-1:0] gen_time;

   initial clock = 1'b0;
   always #2 clock = ~clock;

   function automatic bar_type roll_bar(tick_type t);
      bar_type b;
      bit [63:0] per, st;
      per = ((bar_minutes_q == 0) ? 64'd1 : 64'(bar_minutes_q)) * NS_MIN;
      st = 64'(t.ts) - (64'(t.ts) % per);
      b.fresh = !bar_live || st[TIME_W-1:0] != bar_start_q;
      if (b.fresh) begin
         bar_live = 1'b1;
         bar_start_q = st[TIME_W-1:0];
         bar_px = t.px;
         bar_vol = t.vol;
      end else begin
         for (int s = 0; s < NUM_PRICES; s += 4) begin
            if (t.px[s+P_HIGH] > bar_px[s+P_HIGH]) bar_px[s+P_HIGH] = t.px[s+P_HIGH];
            if (t.px[s+P_LOW] < bar_px[s+P_LOW]) bar_px[s+P_LOW] = t.px[s+P_LOW];
            bar_px[s+P_CLOSE] = t.px[s+P_CLOSE];
         end
      end
      b.start = bar_start_q;
      b.px = bar_px;
      b.vol = bar_vol;
      return b;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(30, 150);
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left <= 0;
      end else begin
         int g;
         g = gap_left;
         if (req_valid && req_ready) begin
            expected_bars.push_back(roll_bar(drv_tick));
            words_in++;
            g = pick_gap();
         end
         if (!req_valid || req_ready) begin
            if (g > 0) begin
               gap_left <= g - 1;
               req_valid <= 1'b0;
            end else if (pending_ticks.size() > 0) begin
               drv_tick = pending_ticks.pop_front();
               gap_left <= 0;
               req_valid <= 1'b1;
               req_tick_time <= drv_tick.ts;
               req_bid_open <= drv_tick.px[P_OPEN];
               req_bid_close <= drv_tick.px[P_CLOSE];
               req_bid_high <= drv_tick.px[P_HIGH];
               req_bid_low <= drv_tick.px[P_LOW];
               req_ask_open <= drv_tick.px[4+P_OPEN];
               req_ask_close <= drv_tick.px[4+P_CLOSE];
               req_ask_high <= drv_tick.px[4+P_HIGH];
               req_ask_low <= drv_tick.px[4+P_LOW];
               req_trade_volume <= drv_tick.vol;
            end else begin
               gap_left <= 0;
               req_valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off
   always @(posedge clock) begin
      if (hold_go && !hold_done) begin
         if (hold_cnt == HOLD_CYCLES) hold_done <= 1'b1;
         else hold_cnt <= hold_cnt + 1;
      end
   end

   always @(posedge clock) begin
      if (reset || (hold_go && !hold_done)) begin
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
         stall_left <= pick_gap();
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   function automatic void check_field(string nm, bit [63:0] exp_v, bit [63:0] act_v);
      if (exp_v !== act_v) begin
         if (mismatches < 10)
            $display("mismatch word %0d %s: exp %0h got %0h", words_out, nm, exp_v, act_v);
         mismatches++;
      end
   endfunction

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         bar_type e;
         if (expected_bars.size() == 0) begin
            if (mismatches < 10) $display("unexpected word at %0t", $realtime);
            mismatches++;
         end else begin
            e = expected_bars.pop_front();
            if (e.fresh) new_bars++;
            check_field("new_bar", 64'(e.fresh), 64'(rsp_new_bar));
            check_field("bar_start", 64'(e.start), 64'(rsp_bar_start));
            check_field("bid_open", 64'(e.px[P_OPEN]), 64'(rsp_out_bid_open));
            check_field("bid_close", 64'(e.px[P_CLOSE]), 64'(rsp_out_bid_close));
            check_field("bid_high", 64'(e.px[P_HIGH]), 64'(rsp_out_bid_high));
            check_field("bid_low", 64'(e.px[P_LOW]), 64'(rsp_out_bid_low));
            check_field("ask_open", 64'(e.px[4+P_OPEN]), 64'(rsp_out_ask_open));
            check_field("ask_close", 64'(e.px[4+P_CLOSE]), 64'(rsp_out_ask_close));
            check_field("ask_high", 64'(e.px[4+P_HIGH]), 64'(rsp_out_ask_high));
            check_field("ask_low", 64'(e.px[4+P_LOW]), 64'(rsp_out_ask_low));
            check_field("volume", 64'(e.vol), 64'(rsp_out_volume));
         end
         words_out++;
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
         $display("== FAIL ==");
         $finish;
      end
   end

   function automatic bit [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic void add_tick(bit [63:0] ts, bit [31:0] fill, bit [31:0] vol);
      tick_type t;
      t.ts = ts[TIME_W-1:0];
      for (int i = 0; i < NUM_PRICES; i++) t.px[i] = fill;
      t.vol = vol;
      pending_ticks.push_back(t);
   endfunction

   function automatic void add_random_ticks(int n, bit [63:0] per);
      tick_type t;
      bit [31:0] base;
      int r;
      base = $urandom;
      for (int k = 0; k < n; k++) begin
         r = $urandom_range(0, 99);
         if (r < 70) gen_time = gen_time + TIME_W'(rand64() % (per / 4 + 1));
         else if (r < 80) gen_time = gen_time + TIME_W'(rand64() % (per * 3));
         else if (r < 88) gen_time = gen_time - TIME_W'(rand64() % per);
         else if (r < 94) gen_time = TIME_W'(rand64());
         t.ts = gen_time;
         for (int i = 0; i < NUM_PRICES; i++)
            t.px[i] = ($urandom_range(0, 1) == 0) ? $urandom
                      : base + $urandom_range(0, 2000) - 1000;
         t.vol = $urandom;
         pending_ticks.push_back(t);
      end
   endfunction

   task automatic csr_write(bit [31:0] v);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= REG_BAR_MINUTES;
      pwdata <= v;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      bar_minutes_q = v[MIN_W-1:0];
   endtask

   task automatic drain();
      do @(posedge clock);
      while (pending_ticks.size() != 0 || req_valid || expected_bars.size() != 0);
      repeat (80) @(posedge clock);
   endtask

   initial begin
      bit [31:0] lens[8];
      bit [63:0] per;
      reset = 1'b1;
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
      req_valid = 1'b0; rsp_ready = 1'b0;
      req_tick_time = '0; req_trade_volume = '0;
      {req_bid_open, req_bid_close, req_bid_high, req_bid_low} = '0;
      {req_ask_open, req_ask_close, req_ask_high, req_ask_low} = '0;
      hold_go = 1'b0; hold_done = 1'b0; hold_cnt = 0;
      stall_left = 0; mismatches = 0; words_in = 0; words_out = 0; new_bars = 0;
      idle_cycles = 0;
      bar_minutes_q = 1; bar_live = 1'b0; bar_start_q = '0; bar_px = '0; bar_vol = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed, reset length of one minute
      add_tick(64'd0, 32'h0, 32'h0);
      add_tick(64'd59999999999, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      add_tick(64'd1, 32'h8000_0000, 32'h1234);
      add_tick(64'h7FFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      add_tick(64'h7FFF_FFFF_FFFF_FFFE, 32'h0, 32'h5);
      add_tick(64'h7FFF_FFFF_FFFF_FFFF, 32'h1, 32'h6);
      add_tick(64'd0, 32'h5555_5555, 32'hAAAA_AAAA);
      add_tick(64'd60000000000, 32'hAAAA_AAAA, 32'h5555_5555);
      add_tick(64'd119999999999, 32'hAAAA_AAAB, 32'h1);
      add_tick(64'd60000000005, 32'hAAAA_AAA9, 32'h2);
      add_tick(64'd59999999999, 32'h7, 32'h3);
      add_tick(64'd120000000000, 32'h7, 32'h4);
      drain();
      csr_write(32'd0);
      add_tick(64'd120000000001, 32'h9, 32'h5);
      add_tick(64'd179999999999, 32'h8, 32'h6);
      drain();

      lens = '{0, 2047, 1440, 1, 7, 32'($urandom_range(1, 1440)),
               32'($urandom_range(1441, 2047)), 1};
      gen_time = TIME_W'(rand64());
      for (int ph = 0; ph < 8; ph++) begin
         csr_write(lens[ph]);
         per = ((bar_minutes_q == 0) ? 64'd1 : 64'(bar_minutes_q)) * NS_MIN;
         add_random_ticks(66, per);
         if (ph == 2) hold_go <= 1'b1;
         drain();
      end

      $display("%0d updates sent, %0d bars checked (%0d new bars), bar lengths 0..2047 min",
               words_in, words_out, new_bars);
      $display("mismatches: %0d", mismatches);
      if (mismatches == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/obar_pkg.sv
rtl/core/obar_front.sv
rtl/core/obar_fifo.sv
rtl/core/obar_back.sv
rtl/core/ohlc_bar_aggregator.sv
dv/tb_top.sv
